>>> rtl/bdt_pkg.sv
// ----------------------------------------------------------------------------
// bdt_pkg
// Shared types and constants for the bracket depth tracker.
// ----------------------------------------------------------------------------
package bdt_pkg;

	localparam int DepthBits  = 12;
	localparam int UnitBits   = 4;
	localparam int IndentBits = 17;
	localparam int QueueDepth = 2;
	localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	// product of the positive depth sum and the indent unit
	localparam int ProdBits = DepthBits + 1 + UnitBits;
	localparam int CmpBits  = (ProdBits > IndentBits) ? ProdBits : IndentBits;
	localparam logic [CmpBits-1:0] IndentMax = CmpBits'((64'd1 << IndentBits) - 64'd1);

	localparam logic [UnitBits-1:0] IndentUnitReset = UnitBits'(2);

	typedef logic signed [DepthBits-1:0] depth_t;
	typedef logic signed [DepthBits+1:0] depth_sum_t;
	typedef logic [UnitBits-1:0]         unit_t;
	typedef logic [IndentBits-1:0]       indent_t;

	localparam depth_t DepthMax = {1'b0, {(DepthBits-1){1'b1}}};
	localparam depth_t DepthMin = {1'b1, {(DepthBits-1){1'b0}}};

	// characters that mean something to the tracker
	localparam logic [7:0] ChParenOpen   = 8'h28;
	localparam logic [7:0] ChParenClose  = 8'h29;
	localparam logic [7:0] ChBracketOpen = 8'h5B;
	localparam logic [7:0] ChBracketClose= 8'h5D;
	localparam logic [7:0] ChBraceOpen   = 8'h7B;
	localparam logic [7:0] ChBraceClose  = 8'h7D;
	localparam logic [7:0] ChDquote      = 8'h22;
	localparam logic [7:0] ChSquote      = 8'h27;
	localparam logic [7:0] ChBackslash   = 8'h5C;
	localparam logic [7:0] ChSemicolon   = 8'h3B;
	localparam logic [7:0] ChHash        = 8'h23;
	localparam logic [7:0] ChNewline     = 8'h0A;

	typedef enum logic [3:0] {
		TK_OTHER,
		TK_PAREN_OPEN,
		TK_PAREN_CLOSE,
		TK_BRACKET_OPEN,
		TK_BRACKET_CLOSE,
		TK_BRACE_OPEN,
		TK_BRACE_CLOSE,
		TK_DQUOTE,
		TK_SQUOTE,
		TK_BACKSLASH,
		TK_COMMENT,
		TK_NEWLINE
	} tok_kind_t;

	typedef struct packed {
		logic      first;
		tok_kind_t kind;
	} token_t;

endpackage

>>> rtl/bdt_front.sv
// ----------------------------------------------------------------------------
// bdt_front
// Input side: takes text beats and reduces each byte to a token kind.
// ----------------------------------------------------------------------------
module bdt_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        ch,
	input  logic              first,
	output logic              push_valid,
	input  logic              push_ready,
	output bdt_pkg::token_t   push_tok
);

	bdt_pkg::tok_kind_t kind;

	always_comb begin
		unique case (ch) inside
			bdt_pkg::ChParenOpen:    kind = bdt_pkg::TK_PAREN_OPEN;
			bdt_pkg::ChParenClose:   kind = bdt_pkg::TK_PAREN_CLOSE;
			bdt_pkg::ChBracketOpen:  kind = bdt_pkg::TK_BRACKET_OPEN;
			bdt_pkg::ChBracketClose: kind = bdt_pkg::TK_BRACKET_CLOSE;
			bdt_pkg::ChBraceOpen:    kind = bdt_pkg::TK_BRACE_OPEN;
			bdt_pkg::ChBraceClose:   kind = bdt_pkg::TK_BRACE_CLOSE;
			bdt_pkg::ChDquote:       kind = bdt_pkg::TK_DQUOTE;
			bdt_pkg::ChSquote:       kind = bdt_pkg::TK_SQUOTE;
			bdt_pkg::ChBackslash:    kind = bdt_pkg::TK_BACKSLASH;
			bdt_pkg::ChSemicolon,
			bdt_pkg::ChHash:         kind = bdt_pkg::TK_COMMENT;
			bdt_pkg::ChNewline:      kind = bdt_pkg::TK_NEWLINE;
			default:                 kind = bdt_pkg::TK_OTHER;
		endcase
	end

	assign push_tok.first = first;
	assign push_tok.kind  = kind;
	assign push_valid     = in_valid;
	assign in_ready       = push_ready;

endmodule

>>> rtl/bdt_queue.sv
// ----------------------------------------------------------------------------
// bdt_queue
// Short token queue between front and back.
// ----------------------------------------------------------------------------
module bdt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  bdt_pkg::token_t push_tok,
	output logic            pop_valid,
	input  logic            pop_ready,
	output bdt_pkg::token_t pop_tok
);

	bdt_pkg::token_t                  mem_q [bdt_pkg::QueueDepth];
	logic [bdt_pkg::QueuePtrW-1:0]    wr_ptr_q;
	logic [bdt_pkg::QueuePtrW-1:0]    rd_ptr_q;
	logic [bdt_pkg::QueueCntW-1:0]    count_q;
	logic                             push;
	logic                             pop;

	assign push_ready = (count_q != bdt_pkg::QueueCntW'(bdt_pkg::QueueDepth));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_tok    = mem_q[rd_ptr_q];

	function automatic logic [bdt_pkg::QueuePtrW-1:0] ptr_inc(
		input logic [bdt_pkg::QueuePtrW-1:0] p
	);
		if (p == bdt_pkg::QueuePtrW'(bdt_pkg::QueueDepth - 1))
			return '0;
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> rtl/bdt_back.sv
// ----------------------------------------------------------------------------
// bdt_back
// Execution side: string/comment/depth state, indent and the result register.
// ----------------------------------------------------------------------------
module bdt_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  bdt_pkg::unit_t        cfg_wdata,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  bdt_pkg::token_t       pop_tok,
	output logic                  out_valid,
	input  logic                  out_ready,
	output bdt_pkg::depth_t       paren_depth,
	output bdt_pkg::depth_t       bracket_depth,
	output bdt_pkg::depth_t       brace_depth,
	output logic                  in_string,
	output logic                  balanced,
	output bdt_pkg::indent_t      indent
);

	bdt_pkg::unit_t   indent_unit_q;
	bdt_pkg::depth_t  paren_q, bracket_q, brace_q;
	logic             string_q, dquote_q, escape_q, comment_q;

	bdt_pkg::depth_t  paren_b, bracket_b, brace_b;
	logic             string_b, dquote_b, escape_b, comment_b;
	bdt_pkg::depth_t  paren_n, bracket_n, brace_n;
	logic             string_n, dquote_n, escape_n, comment_n;

	bdt_pkg::depth_sum_t          sum;
	logic [bdt_pkg::ProdBits-1:0] prod;
	logic [bdt_pkg::CmpBits-1:0]  prod_ext;
	bdt_pkg::indent_t             indent_n;

	logic             out_valid_q;
	bdt_pkg::depth_t  paren_out_q, bracket_out_q, brace_out_q;
	logic             string_out_q, balanced_out_q;
	bdt_pkg::indent_t indent_out_q;
	logic             pop;

	assign pop_ready = !out_valid_q || out_ready;
	assign pop       = pop_valid && pop_ready;

	// a first beat starts from cleared state
	always_comb begin
		if (pop_tok.first) begin
			paren_b   = '0;
			bracket_b = '0;
			brace_b   = '0;
			string_b  = 1'b0;
			dquote_b  = 1'b0;
			escape_b  = 1'b0;
			comment_b = 1'b0;
		end else begin
			paren_b   = paren_q;
			bracket_b = bracket_q;
			brace_b   = brace_q;
			string_b  = string_q;
			dquote_b  = dquote_q;
			escape_b  = escape_q;
			comment_b = comment_q;
		end
	end

	always_comb begin
		paren_n   = paren_b;
		bracket_n = bracket_b;
		brace_n   = brace_b;
		string_n  = string_b;
		dquote_n  = dquote_b;
		escape_n  = escape_b;
		comment_n = comment_b;
		if (comment_b) begin
			if (pop_tok.kind == bdt_pkg::TK_NEWLINE)
				comment_n = 1'b0;
		end else if (string_b) begin
			if (escape_b)
				escape_n = 1'b0;
			else if (pop_tok.kind == bdt_pkg::TK_BACKSLASH)
				escape_n = 1'b1;
			else if ((dquote_b && pop_tok.kind == bdt_pkg::TK_DQUOTE) ||
					(!dquote_b && pop_tok.kind == bdt_pkg::TK_SQUOTE))
				string_n = 1'b0;
		end else begin
			unique case (pop_tok.kind)
				bdt_pkg::TK_DQUOTE: begin
					string_n = 1'b1;
					dquote_n = 1'b1;
				end
				bdt_pkg::TK_SQUOTE: begin
					string_n = 1'b1;
					dquote_n = 1'b0;
				end
				bdt_pkg::TK_COMMENT: comment_n = 1'b1;
				bdt_pkg::TK_PAREN_OPEN:
					if (paren_b != bdt_pkg::DepthMax) paren_n = paren_b + 1'b1;
				bdt_pkg::TK_PAREN_CLOSE:
					if (paren_b != bdt_pkg::DepthMin) paren_n = paren_b - 1'b1;
				bdt_pkg::TK_BRACKET_OPEN:
					if (bracket_b != bdt_pkg::DepthMax) bracket_n = bracket_b + 1'b1;
				bdt_pkg::TK_BRACKET_CLOSE:
					if (bracket_b != bdt_pkg::DepthMin) bracket_n = bracket_b - 1'b1;
				bdt_pkg::TK_BRACE_OPEN:
					if (brace_b != bdt_pkg::DepthMax) brace_n = brace_b + 1'b1;
				bdt_pkg::TK_BRACE_CLOSE:
					if (brace_b != bdt_pkg::DepthMin) brace_n = brace_b - 1'b1;
				default: ;
			endcase
		end
	end

	// indent = positive depth sum times unit, clipped to the output range
	always_comb begin
		sum = bdt_pkg::depth_sum_t'(paren_n) + bdt_pkg::depth_sum_t'(bracket_n)
			+ bdt_pkg::depth_sum_t'(brace_n);
		prod = bdt_pkg::ProdBits'(sum[bdt_pkg::DepthBits:0])
			* bdt_pkg::ProdBits'(indent_unit_q);
		prod_ext = bdt_pkg::CmpBits'(prod);
		if (sum <= 0)
			indent_n = '0;
		else if (prod_ext > bdt_pkg::IndentMax)
			indent_n = bdt_pkg::IndentBits'(bdt_pkg::IndentMax);
		else
			indent_n = bdt_pkg::IndentBits'(prod_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			indent_unit_q <= bdt_pkg::IndentUnitReset;
			paren_q       <= '0;
			bracket_q     <= '0;
			brace_q       <= '0;
			string_q      <= 1'b0;
			dquote_q      <= 1'b0;
			escape_q      <= 1'b0;
			comment_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we)
				indent_unit_q <= cfg_wdata;
			if (pop) begin
				paren_q     <= paren_n;
				bracket_q   <= bracket_n;
				brace_q     <= brace_n;
				string_q    <= string_n;
				dquote_q    <= dquote_n;
				escape_q    <= escape_n;
				comment_q   <= comment_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			paren_out_q    <= paren_n;
			bracket_out_q  <= bracket_n;
			brace_out_q    <= brace_n;
			string_out_q   <= string_n;
			balanced_out_q <= (paren_n == '0) && (bracket_n == '0) && (brace_n == '0)
				&& !string_n;
			indent_out_q   <= indent_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign paren_depth   = paren_out_q;
	assign bracket_depth = bracket_out_q;
	assign brace_depth   = brace_out_q;
	assign in_string     = string_out_q;
	assign balanced      = balanced_out_q;
	assign indent        = indent_out_q;

	// a first beat leaves every depth within one of zero
	a_first_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && pop_tok.first |=>
			(paren_q == 1 || paren_q == 0 || paren_q == -1) &&
			(bracket_q == 1 || bracket_q == 0 || bracket_q == -1) &&
			(brace_q == 1 || brace_q == 0 || brace_q == -1))
		else $error("depth not near zero after first beat");

	// inside a comment the depths do not move
	a_comment_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pop && comment_q && !pop_tok.first |=>
			$stable(paren_q) && $stable(bracket_q) && $stable(brace_q) && !string_q)
		else $error("depth changed inside comment");

	// one beat moves at most one counter
	a_one_counter: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !pop_tok.first |=>
			$countones({paren_q != $past(paren_q), bracket_q != $past(bracket_q),
				brace_q != $past(brace_q)}) <= 1)
		else $error("more than one depth counter moved");

	// the result register only loads from a popped token
	a_out_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pop))
		else $error("result appeared without a token");

endmodule

>>> rtl/bracket_depth_tracker_core.sv
// ----------------------------------------------------------------------------
// bracket_depth_tracker_core
// Streaming bracket balance tracker for source text, one byte per beat.
// Each beat is registered in the token queue, then its result in the back's
// result register. Throughput: one beat per cycle while results are taken;
// the depth/flag update is combinational on the registered state.
// A stalled result lets two more beats into the queue before in_ready drops.
// Reset clears all tracking state and sets indent_unit to 2; first clears
// the tracking state (not indent_unit) before its byte is applied.
// ----------------------------------------------------------------------------
module bracket_depth_tracker_core (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration: indent columns per open level
	input  logic                     cfg_we,
	input  bdt_pkg::unit_t           cfg_wdata,
	// text input channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [7:0]               ch,
	input  logic                     first,
	// result channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output bdt_pkg::depth_t          paren_depth,
	output bdt_pkg::depth_t          bracket_depth,
	output bdt_pkg::depth_t          brace_depth,
	output logic                     in_string,
	output logic                     balanced,
	output bdt_pkg::indent_t         indent
);

	// Front classifies each byte into a token; the two-entry queue lets the
	// input keep taking beats while a result waits at the output.
	logic            push_valid;
	logic            push_ready;
	bdt_pkg::token_t push_tok;
	logic            pop_valid;
	logic            pop_ready;
	bdt_pkg::token_t pop_tok;

	bdt_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.ch         (ch),
		.first      (first),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_tok   (push_tok)
	);

	bdt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_tok   (push_tok),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_tok    (pop_tok)
	);

	// Back owns the string/escape/comment flags and saturating counters, and
	// registers each result beat (indent is computed from the updated depths).
	bdt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_tok       (pop_tok),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.paren_depth   (paren_depth),
		.bracket_depth (bracket_depth),
		.brace_depth   (brace_depth),
		.in_string     (in_string),
		.balanced      (balanced),
		.indent        (indent)
	);

endmodule
